>>> sv/cfp_pkg.sv
package cfp_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;
  localparam logic [7:0] MODE_MEAS  = 8'h00;
  localparam logic [7:0] MODE_CALIB = 8'h01;
  localparam logic [7:0] MODE_TEST  = 8'h02;

  // Frame lengths in bytes after the mode byte: payload plus two check bytes
  localparam int LEN_MEAS  = 6;
  localparam int LEN_CALIB = 9;
  localparam int LEN_TEST  = 7;

  // Byte index of the AND check (last byte) and of the XOR check
  localparam logic [3:0] LAST_MEAS  = 4'(LEN_MEAS - 1);
  localparam logic [3:0] LAST_CALIB = 4'(LEN_CALIB - 1);
  localparam logic [3:0] LAST_TEST  = 4'(LEN_TEST - 1);
  localparam logic [3:0] CHK_MEAS   = 4'(LEN_MEAS - 2);
  localparam logic [3:0] CHK_CALIB  = 4'(LEN_CALIB - 2);
  localparam logic [3:0] CHK_TEST   = 4'(LEN_TEST - 2);

  // Frame tracker state codes
  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_MEAS  = 2'd1;
  localparam logic [1:0] KIND_CALIB = 2'd2;
  localparam logic [1:0] KIND_TEST  = 2'd3;

  // Reported frame types
  localparam logic [1:0] TYPE_MEAS  = 2'd0;
  localparam logic [1:0] TYPE_CALIB = 2'd1;
  localparam logic [1:0] TYPE_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0] frame_type;
    logic       check_passed;
    logic [7:0] freq_index;
    logic [7:0] chip_select;
    logic [7:0] direction;
    logic [7:0] table_gain_index;
    logic [7:0] table_phase_index;
    logic [7:0] gain_value;
    logic [7:0] phase_value;
  } result_t;

endpackage

>>> sv/cfp_frame.sv
module cfp_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [7:0]        rx_byte,
  output logic              done,
  output cfp_pkg::result_t  result
);

  logic [7:0] prev_byte;
  logic [1:0] kind;
  logic [3:0] cnt;
  logic [7:0] store [8];
  logic [7:0] xacc;
  logic [7:0] aacc;
  logic       xok;

  logic [3:0] cnt_last;
  logic [3:0] cnt_chk;
  logic       last;
  logic       ok;

  always_comb begin
    case (kind)
      cfp_pkg::KIND_MEAS: begin
        cnt_last = cfp_pkg::LAST_MEAS;
        cnt_chk  = cfp_pkg::CHK_MEAS;
      end
      cfp_pkg::KIND_CALIB: begin
        cnt_last = cfp_pkg::LAST_CALIB;
        cnt_chk  = cfp_pkg::CHK_CALIB;
      end
      default: begin
        cnt_last = cfp_pkg::LAST_TEST;
        cnt_chk  = cfp_pkg::CHK_TEST;
      end
    endcase
  end

  assign last = (cnt == cnt_last);
  assign done = beat && (kind != cfp_pkg::KIND_IDLE) && last;
  assign ok   = xok && (aacc == rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= 8'd0;
      kind      <= cfp_pkg::KIND_IDLE;
      cnt       <= 4'd0;
    end else if (beat) begin
      prev_byte <= rx_byte;
      if (kind == cfp_pkg::KIND_IDLE) begin
        if (prev_byte == cfp_pkg::START_BYTE) begin
          cnt <= 4'd0;
          case (rx_byte)
            cfp_pkg::MODE_MEAS:  kind <= cfp_pkg::KIND_MEAS;
            cfp_pkg::MODE_CALIB: kind <= cfp_pkg::KIND_CALIB;
            cfp_pkg::MODE_TEST:  kind <= cfp_pkg::KIND_TEST;
            default:             kind <= cfp_pkg::KIND_IDLE;
          endcase
        end
      end else if (last) begin
        kind <= cfp_pkg::KIND_IDLE;
        cnt  <= 4'd0;
      end else begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  // Payload bytes and running checks; seeded at every frame start
  always_ff @(posedge clk) begin
    if (beat) begin
      if (kind == cfp_pkg::KIND_IDLE) begin
        xacc <= 8'h00;
        aacc <= 8'hFF;
      end else if (!last) begin
        store[cnt[2:0]] <= rx_byte;
        if (cnt < cnt_chk) begin
          xacc <= xacc ^ rx_byte;
          aacc <= aacc & rx_byte;
        end
        if (cnt == cnt_chk) begin
          xok <= (rx_byte == xacc);
        end
      end
    end
  end

  always_comb begin
    result                   = '0;
    result.frame_type        = kind - 2'd1;
    result.check_passed      = ok;
    if (ok) begin
      if (kind == cfp_pkg::KIND_MEAS) begin
        result.chip_select   = store[0];
        result.direction     = store[1];
        result.gain_value    = store[2];
        result.phase_value   = store[3];
      end else begin
        result.freq_index        = store[0];
        result.chip_select       = store[1];
        result.direction         = store[2];
        result.table_gain_index  = store[3];
        result.table_phase_index = store[4];
        if (kind == cfp_pkg::KIND_CALIB) begin
          result.gain_value  = store[5];
          result.phase_value = store[6];
        end
      end
    end
  end

endmodule

>>> sv/checked_command_frame_parser_top.sv
// Command frame parser for a byte stream from a serial receiver.
// Input channel: one rx_byte per beat (in_valid / in_stall). A frame is the
// start byte 0xFE, a mode byte (0x00 measure, 0x01 calibrate, 0x02 test), the
// payload (4, 7 or 5 bytes), then the XOR and the AND of the payload bytes.
// Output channel: one result beat per frame (out_valid / out_stall) carrying
// frame_type, check_passed and the decoded fields. A failed check gives
// frame_type with every other field zero. Bytes outside a frame give nothing.
// The result appears in the cycle after the last check byte is taken.
// Throughput: one byte per cycle unless stalled; frame state and the running
// XOR/AND checks sit in registers updated per byte, so the final byte only
// needs a compare. A single output register holds a finished result; while
// it is stalled, in_stall is raised and the held result stays unchanged.
// Reset (rst, synchronous): tracker returns to idle, previous byte clears,
// the output register empties. No result is lost or repeated under stall.
module checked_command_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] frame_type,
  output logic       check_passed,
  output logic [7:0] freq_index,
  output logic [7:0] chip_select,
  output logic [7:0] direction,
  output logic [7:0] table_gain_index,
  output logic [7:0] table_phase_index,
  output logic [7:0] gain_value,
  output logic [7:0] phase_value
);

  logic             beat;
  logic             done;
  cfp_pkg::result_t result;
  cfp_pkg::result_t held;
  logic             out_valid_next;

  assign in_stall = out_valid && out_stall;
  assign beat     = in_valid && !in_stall;

  cfp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .rx_byte (rx_byte),
    .done    (done),
    .result  (result)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (beat && done) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Load only when the output register is free, else hold
  always_ff @(posedge clk) begin
    if (beat && done) begin
      held <= result;
    end
  end

  assign frame_type        = held.frame_type;
  assign check_passed      = held.check_passed;
  assign freq_index        = held.freq_index;
  assign chip_select       = held.chip_select;
  assign direction         = held.direction;
  assign table_gain_index  = held.table_gain_index;
  assign table_phase_index = held.table_phase_index;
  assign gain_value        = held.gain_value;
  assign phase_value       = held.phase_value;

endmodule

>>> sv/cfp_checker.sv
module cfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] frame_type,
  input logic       check_passed,
  input logic [7:0] freq_index,
  input logic [7:0] chip_select,
  input logic [7:0] direction,
  input logic [7:0] table_gain_index,
  input logic [7:0] table_phase_index,
  input logic [7:0] gain_value,
  input logic [7:0] phase_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_type) && $stable(gain_value))
    else $error("stalled result beat dropped or changed");

  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result beat is stalled");

  a_type_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_type != 2'd3)
    else $error("undefined frame type");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !check_passed |-> freq_index == 8'd0 && chip_select == 8'd0 &&
      direction == 8'd0 && table_gain_index == 8'd0 && table_phase_index == 8'd0 &&
      gain_value == 8'd0 && phase_value == 8'd0)
    else $error("failed frame carries nonzero fields");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_type == cfp_pkg::TYPE_TEST && gain_value == 8'd0 &&
      phase_value == 8'd0) || (frame_type == cfp_pkg::TYPE_MEAS && freq_index == 8'd0 &&
      table_gain_index == 8'd0 && table_phase_index == 8'd0) ||
      frame_type == cfp_pkg::TYPE_CALIB)
    else $error("unused field of frame type not zero");

endmodule

bind checked_command_frame_parser_top cfp_checker u_cfp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .frame_type        (frame_type),
  .check_passed      (check_passed),
  .freq_index        (freq_index),
  .chip_select       (chip_select),
  .direction         (direction),
  .table_gain_index  (table_gain_index),
  .table_phase_index (table_phase_index),
  .gain_value        (gain_value),
  .phase_value       (phase_value)
);
